@@ rtl/core/vsat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vsat_pkg;

  localparam int unsigned DOT_W  = 9;
  localparam int unsigned ADDR_W = 15;

  localparam logic [DOT_W-1:0] DOTS_PER_LINE    = 9'd341;
  localparam logic [DOT_W-1:0] LAST_LINE        = 9'd261;
  localparam logic [DOT_W-1:0] VBLANK_LINE      = 9'd242;
  localparam logic [DOT_W-1:0] RENDER_LAST_LINE = 9'd240;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  typedef struct packed {
    logic coarse_x;
    logic v_copy;
    logic y_step;
    logic h_copy;
    logic status_clr;
    logic vbl_set;
    logic frame;
  } tick_evt_t;

endpackage

`default_nettype wire

@@ rtl/core/vsat_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface vsat_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, op, reg_select, write_data, input ready);
  modport sink (input valid, op, reg_select, write_data, output ready);
endinterface

interface vsat_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [14:0] vram_addr;
  logic [2:0]  fine_x_out;
  logic        mem_write;
  logic        nmi_pulse;
  logic        frame_done;
  logic [8:0]  dot_out;
  logic [8:0]  line_out;

  modport source (output valid, read_data, vram_addr, fine_x_out, mem_write, nmi_pulse,
                  frame_done, dot_out, line_out, input ready);
  modport sink (input valid, read_data, vram_addr, fine_x_out, mem_write, nmi_pulse,
                frame_done, dot_out, line_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vsat_timing.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vsat_timing #(
  parameter logic [vsat_pkg::DOT_W-1:0] DOTS_PER_LINE = vsat_pkg::DOTS_PER_LINE,
  parameter logic [vsat_pkg::DOT_W-1:0] LAST_LINE     = vsat_pkg::LAST_LINE
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tick,
  input  wire logic                          rendering,
  output vsat_pkg::tick_evt_t                evt,
  output logic [vsat_pkg::DOT_W-1:0]         dot_next,
  output logic [vsat_pkg::DOT_W-1:0]         line_next
);

  logic [vsat_pkg::DOT_W-1:0] dot;
  logic [vsat_pkg::DOT_W-1:0] line;
  logic                       odd_frame;
  logic                       odd_frame_next;

  logic                     render_line;
  logic                     active;
  logic                     fetch_window;
  logic                     skip;
  logic [vsat_pkg::DOT_W:0] dot_inc;
  logic [vsat_pkg::DOT_W:0] line_inc;

  always_comb begin
    render_line  = (line <= vsat_pkg::RENDER_LAST_LINE);
    active       = tick && render_line && rendering;
    fetch_window = ((dot >= 9'd2) && (dot < 9'd258)) || ((dot >= 9'd321) && (dot < 9'd338));

    evt.coarse_x   = active && fetch_window && (dot[2:0] == 3'd0);
    evt.v_copy     = active && (line == 9'd0) && (dot >= 9'd280) && (dot < 9'd305);
    evt.y_step     = active && (dot == 9'd256);
    evt.h_copy     = active && (dot == 9'd257);
    evt.status_clr = tick && render_line && (line == 9'd0) && (dot == 9'd1);
    evt.vbl_set    = tick && (line == vsat_pkg::VBLANK_LINE) && (dot == 9'd1);
    skip           = active && (line == 9'd1) && (dot == 9'd0) && odd_frame;

    dot_inc        = skip ? 10'd2 : ({1'b0, dot} + 10'd1);
    line_inc       = {1'b0, line};
    evt.frame      = 1'b0;
    odd_frame_next = odd_frame;
    dot_next       = dot;
    line_next      = line;
    if (tick) begin
      if (dot_inc >= {1'b0, DOTS_PER_LINE}) begin
        dot_inc  = '0;
        line_inc = {1'b0, line} + 10'd1;
        if (line_inc > {1'b0, LAST_LINE}) begin
          line_inc       = '0;
          evt.frame      = 1'b1;
          odd_frame_next = ~odd_frame;
        end
      end
      dot_next  = dot_inc[vsat_pkg::DOT_W-1:0];
      line_next = line_inc[vsat_pkg::DOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot       <= '0;
      line      <= '0;
      odd_frame <= 1'b0;
    end else begin
      dot       <= dot_next;
      line      <= line_next;
      odd_frame <= odd_frame_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vsat_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vsat_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           fire,
  input  wire logic [1:0]                     op,
  input  wire logic [2:0]                     reg_select,
  input  wire logic [7:0]                     write_data,
  input  wire vsat_pkg::tick_evt_t            evt,
  output logic                                rendering,
  output logic [vsat_pkg::ADDR_W-1:0]         addr_next,
  output logic [2:0]                          fine_x_next,
  output logic [7:0]                          read_data,
  output logic                                mem_write,
  output logic                                nmi_pulse
);

  logic [7:0]                  control_reg;
  logic [7:0]                  mask_reg;
  logic                        vblank;
  logic                        write_toggle;
  logic [2:0]                  fine_x;
  logic [vsat_pkg::ADDR_W-1:0] temp_address;
  logic [vsat_pkg::ADDR_W-1:0] current_address;

  logic [7:0]                  control_reg_next;
  logic [7:0]                  mask_reg_next;
  logic                        vblank_next;
  logic                        write_toggle_next;
  logic [vsat_pkg::ADDR_W-1:0] temp_address_next;

  function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
    logic [14:0] r;
    if (a[4:0] == 5'd31) begin
      r = {a[14:5], 5'd0} ^ 15'h0400;
    end else begin
      r = a + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] step_y(input logic [14:0] a);
    logic [14:0] r;
    logic [4:0]  cy;
    r  = a;
    cy = a[9:5];
    if (a[14:12] != 3'd7) begin
      r[14:12] = a[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (cy == 5'd29) begin
        cy    = 5'd0;
        r[11] = ~r[11];
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r[9:5] = cy;
    end
    return r;
  endfunction

  always_comb begin
    rendering         = |mask_reg[4:3];
    control_reg_next  = control_reg;
    mask_reg_next     = mask_reg;
    vblank_next       = vblank;
    write_toggle_next = write_toggle;
    fine_x_next       = fine_x;
    temp_address_next = temp_address;
    addr_next         = current_address;
    read_data         = 8'd0;
    mem_write         = 1'b0;
    nmi_pulse         = 1'b0;

    unique case (op)
      vsat_pkg::OP_TICK: begin
        if (evt.coarse_x) begin
          addr_next = step_coarse_x(addr_next);
        end
        if (evt.v_copy) begin
          addr_next = (addr_next & 15'h041F) | (temp_address & 15'h7BE0);
        end
        if (evt.y_step) begin
          addr_next = step_y(addr_next);
        end
        if (evt.h_copy) begin
          addr_next = (addr_next & 15'h7BE0) | (temp_address & 15'h041F);
        end
        if (evt.status_clr) begin
          vblank_next = 1'b0;
        end
        if (evt.vbl_set) begin
          vblank_next = 1'b1;
          nmi_pulse   = control_reg[7];
        end
      end
      vsat_pkg::OP_READ: begin
        if (reg_select == vsat_pkg::REG_STATUS) begin
          read_data         = {vblank, 7'd0};
          vblank_next       = 1'b0;
          write_toggle_next = 1'b0;
        end
      end
      vsat_pkg::OP_WRITE: begin
        unique case (reg_select)
          vsat_pkg::REG_CTRL: control_reg_next = write_data;
          vsat_pkg::REG_MASK: mask_reg_next = write_data;
          vsat_pkg::REG_SCROLL: begin
            if (!write_toggle) begin
              fine_x_next            = write_data[2:0];
              temp_address_next[4:0] = write_data[7:3];
            end else begin
              temp_address_next[14:12] = write_data[2:0];
              temp_address_next[9:5]   = write_data[7:3];
            end
            write_toggle_next = ~write_toggle;
          end
          vsat_pkg::REG_ADDR: begin
            if (!write_toggle) begin
              temp_address_next[14:8] = {1'b0, write_data[5:0]};
            end else begin
              temp_address_next[7:0] = write_data;
              addr_next              = {temp_address[14:8], write_data};
            end
            write_toggle_next = ~write_toggle;
          end
          vsat_pkg::REG_DATA: begin
            mem_write = 1'b1;
            addr_next = current_address + (control_reg[2] ? 15'd32 : 15'd1);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg     <= '0;
      mask_reg        <= '0;
      vblank          <= 1'b0;
      write_toggle    <= 1'b0;
      fine_x          <= '0;
      temp_address    <= '0;
      current_address <= '0;
    end else if (fire) begin
      control_reg     <= control_reg_next;
      mask_reg        <= mask_reg_next;
      vblank          <= vblank_next;
      write_toggle    <= write_toggle_next;
      fine_x          <= fine_x_next;
      temp_address    <= temp_address_next;
      current_address <= addr_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/video_scroll_address_timing_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields
// req      in   op, reg_select, write_data
// rsp      out  read_data, vram_addr, fine_x_out, mem_write, nmi_pulse, frame_done,
//               dot_out, line_out
//
// One transaction per clock while rsp is not stalled; req passes the input and result registers.
// The input register feeds the timing and scroll logic, whose outputs load the result register.
// Reset clears counters, scroll address pair, fine X, toggle, vblank, control and mask.
// A stalled rsp holds the result; req keeps flowing while the input register can drain.

module video_scroll_address_timing_core #(
  parameter logic [vsat_pkg::DOT_W-1:0] DOTS_PER_LINE = vsat_pkg::DOTS_PER_LINE,
  parameter logic [vsat_pkg::DOT_W-1:0] LAST_LINE     = vsat_pkg::LAST_LINE
) (
  input wire logic clk,
  input wire logic rst,
  vsat_req_if.sink   req,
  vsat_rsp_if.source rsp
);

  logic       in_vld;
  logic [1:0] in_op;
  logic [2:0] in_sel;
  logic [7:0] in_data;
  logic       out_vld;
  logic       adv;
  logic       tick;

  vsat_pkg::tick_evt_t         evt;
  logic                        rendering;
  logic [vsat_pkg::DOT_W-1:0]  dot_next;
  logic [vsat_pkg::DOT_W-1:0]  line_next;
  logic [vsat_pkg::ADDR_W-1:0] addr_next;
  logic [2:0]                  fine_x_next;
  logic [7:0]                  read_data;
  logic                        mem_write;
  logic                        nmi_pulse;

  assign adv       = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || adv;
  assign tick      = adv && (in_op == vsat_pkg::OP_TICK);
  assign rsp.valid = out_vld;

  vsat_timing #(
    .DOTS_PER_LINE (DOTS_PER_LINE),
    .LAST_LINE     (LAST_LINE)
  ) u_timing (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .rendering (rendering),
    .evt       (evt),
    .dot_next  (dot_next),
    .line_next (line_next)
  );

  vsat_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .fire        (adv),
    .op          (in_op),
    .reg_select  (in_sel),
    .write_data  (in_data),
    .evt         (evt),
    .rendering   (rendering),
    .addr_next   (addr_next),
    .fine_x_next (fine_x_next),
    .read_data   (read_data),
    .mem_write   (mem_write),
    .nmi_pulse   (nmi_pulse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (req.ready) begin
        in_vld <= req.valid;
      end
      if (adv) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
    if (req.valid && req.ready) begin
      in_op   <= req.op;
      in_sel  <= req.reg_select;
      in_data <= req.write_data;
    end
    if (adv) begin
      rsp.read_data  <= read_data;
      rsp.vram_addr  <= addr_next;
      rsp.fine_x_out <= fine_x_next;
      rsp.mem_write  <= mem_write;
      rsp.nmi_pulse  <= nmi_pulse;
      rsp.frame_done <= evt.frame;
      rsp.dot_out    <= dot_next;
      rsp.line_out   <= line_next;
    end
  end

  a_nmi_at_vblank: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.nmi_pulse) |->
      (rsp.line_out == vsat_pkg::VBLANK_LINE) && (rsp.dot_out == 9'd2))
    else $error("nmi pulse away from vblank start");

  a_frame_at_origin: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.frame_done) |-> (rsp.line_out == 9'd0) && (rsp.dot_out == 9'd0))
    else $error("frame done away from counter wrap");

  a_dot_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.dot_out < DOTS_PER_LINE) &&
                  (rsp.line_out <= LAST_LINE))
    else $error("dot or line counter out of range");

  a_write_no_tick: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.mem_write) |-> !rsp.nmi_pulse && !rsp.frame_done)
    else $error("memory write together with tick event");

endmodule

`default_nettype wire
